// ----- rtl/quoted_key_value_tokenizer_core_assert.svh -----
// Assertion macros used by the checker file of the tokenizer core.
// Each macro expects clk and rst in scope.
`ifndef QUOTED_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_KEY_VALUE_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define QKVT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tokenizer check failed");

// Next-cycle implication, held off during reset
`define QKVT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tokenizer check failed");

`endif

// ----- rtl/qkvt_pkg.sv -----
package qkvt_pkg;

  // Input beat
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_mark;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [3:0] error_code;
    logic       last_of_run;
  } out_beat_t;

  // Queue entry: up to two results caused by one input beat
  typedef struct packed {
    logic      two;
    out_beat_t r0;
    out_beat_t r1;
  } act_t;

  // Result kinds
  localparam logic [2:0] KIND_KEY  = 3'd0;
  localparam logic [2:0] KIND_VAL  = 3'd1;
  localparam logic [2:0] KIND_PAIR = 3'd2;
  localparam logic [2:0] KIND_ERR  = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  // Error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_EMPTY    = 4'd1;
  localparam logic [3:0] ERR_QBEFORE  = 4'd2;
  localparam logic [3:0] ERR_QAFTER   = 4'd3;
  localparam logic [3:0] ERR_EOF      = 4'd4;
  localparam logic [3:0] ERR_EQUALS   = 4'd5;
  localparam logic [3:0] ERR_STRSTART = 4'd6;
  localparam logic [3:0] ERR_NEWLINE  = 4'd7;
  localparam logic [3:0] ERR_SEMI     = 4'd8;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_key_byte(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER) || (c == CH_HASH);
  endfunction

endpackage

// ----- rtl/qkvt_front.sv -----
module qkvt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               full,
  input  qkvt_pkg::in_beat_t byte_beat,
  output logic               push,
  output qkvt_pkg::act_t     push_data
);

  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_KEYWAIT  = 4'd1;
  localparam logic [3:0] PH_KEY      = 4'd2;
  localparam logic [3:0] PH_EQWAIT   = 4'd3;
  localparam logic [3:0] PH_VALWAIT  = 4'd4;
  localparam logic [3:0] PH_VALUE    = 4'd5;
  localparam logic [3:0] PH_ESC      = 4'd6;
  localparam logic [3:0] PH_SEMIWAIT = 4'd7;
  localparam logic [3:0] PH_HALT     = 4'd8;

  logic [3:0]          phase;
  logic [3:0]          phase_next;
  logic [1:0]          n;
  logic [7:0]          c;
  logic                accept;
  qkvt_pkg::out_beat_t r0;
  qkvt_pkg::out_beat_t r1;

  assign c      = byte_beat.byte_in;
  assign accept = byte_valid && !full;

  // Classify the beat against the current phase
  always_comb begin
    phase_next = phase;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    if (byte_beat.end_mark) begin
      phase_next = PH_START;
      case (phase)
        PH_START: begin
          r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_EMPTY; n = 2'd1;
        end
        PH_KEYWAIT: begin
          r0.kind = qkvt_pkg::KIND_DONE; n = 2'd1;
        end
        PH_KEY: begin
          r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_QAFTER; n = 2'd1;
        end
        PH_HALT: begin
          n = 2'd0;
        end
        default: begin
          r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_EOF; n = 2'd1;
        end
      endcase
    end else begin
      case (phase)
        PH_START, PH_KEYWAIT: begin
          if (c == qkvt_pkg::CH_QUOTE) begin
            phase_next = PH_KEY;
          end else if (qkvt_pkg::is_space(c)) begin
            phase_next = PH_KEYWAIT;
          end else begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_QBEFORE;
            n = 2'd1; phase_next = PH_HALT;
          end
        end
        PH_KEY: begin
          if (c == qkvt_pkg::CH_QUOTE) begin
            phase_next = PH_EQWAIT;
          end else if (qkvt_pkg::is_key_byte(c)) begin
            r0.kind = qkvt_pkg::KIND_KEY; r0.data_byte = c; n = 2'd1;
          end else begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_QAFTER;
            n = 2'd1; phase_next = PH_HALT;
          end
        end
        PH_EQWAIT: begin
          if (c == qkvt_pkg::CH_EQ) begin
            phase_next = PH_VALWAIT;
          end else if (!qkvt_pkg::is_space(c)) begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_EQUALS;
            n = 2'd1; phase_next = PH_HALT;
          end
        end
        PH_VALWAIT: begin
          if (c == qkvt_pkg::CH_QUOTE) begin
            phase_next = PH_VALUE;
          end else if (!qkvt_pkg::is_space(c)) begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_STRSTART;
            n = 2'd1; phase_next = PH_HALT;
          end
        end
        PH_VALUE: begin
          if (c == qkvt_pkg::CH_QUOTE) begin
            phase_next = PH_SEMIWAIT;
          end else if (c == qkvt_pkg::CH_LF) begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_NEWLINE;
            n = 2'd1; phase_next = PH_HALT;
          end else if (c == qkvt_pkg::CH_BSL) begin
            phase_next = PH_ESC;
          end else begin
            r0.kind = qkvt_pkg::KIND_VAL; r0.data_byte = c; n = 2'd1;
          end
        end
        PH_ESC: begin
          phase_next = PH_VALUE;
          r0.kind    = qkvt_pkg::KIND_VAL;
          if ((c == qkvt_pkg::CH_QUOTE) || (c == qkvt_pkg::CH_BSL)) begin
            r0.data_byte = c; n = 2'd1;
          end else if (c == qkvt_pkg::CH_N) begin
            r0.data_byte = qkvt_pkg::CH_LF; n = 2'd1;
          end else begin
            // Unknown escape: keep the backslash, then handle the byte
            r0.data_byte = qkvt_pkg::CH_BSL;
            n = 2'd2;
            if (c == qkvt_pkg::CH_LF) begin
              r1.kind = qkvt_pkg::KIND_ERR; r1.error_code = qkvt_pkg::ERR_NEWLINE;
              phase_next = PH_HALT;
            end else begin
              r1.kind = qkvt_pkg::KIND_VAL; r1.data_byte = c;
            end
          end
        end
        PH_SEMIWAIT: begin
          if (c == qkvt_pkg::CH_SEMI) begin
            r0.kind = qkvt_pkg::KIND_PAIR; n = 2'd1; phase_next = PH_KEYWAIT;
          end else if (!qkvt_pkg::is_space(c)) begin
            r0.kind = qkvt_pkg::KIND_ERR; r0.error_code = qkvt_pkg::ERR_SEMI;
            n = 2'd1; phase_next = PH_HALT;
          end
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  // Advance the phase on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Queue only beats that cause results
  assign push          = accept && (n != 2'd0);
  assign push_data.two = (n == 2'd2);
  assign push_data.r0  = r0;
  assign push_data.r1  = r1;

endmodule

// ----- rtl/qkvt_fifo.sv -----
module qkvt_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qkvt_pkg::act_t push_data,
  input  logic           pop,
  output qkvt_pkg::act_t head,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qkvt_pkg::act_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/qkvt_back.sv -----
module qkvt_back (
  input  logic                clk,
  input  logic                rst,
  input  qkvt_pkg::act_t      head,
  input  logic                empty,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output qkvt_pkg::out_beat_t res_beat
);

  logic load;
  logic take;
  logic sel;

  assign load = !res_valid || !res_stall;
  assign take = load && !empty;
  assign pop  = take && (!head.two || sel);

  // Hold the output beat until taken; step through one or two results
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      res_valid <= !empty;
      if (take) begin
        sel <= head.two && !sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_beat <= sel ? head.r1 : head.r0;
    end
  end

endmodule

// ----- rtl/quoted_key_value_tokenizer_core.sv -----
// Result path: an accepted beat is queued, then loaded into the output register.
// Throughput: one input beat per cycle while the queue is not full; the output register
//   drains one result per cycle while res_stall is low. A beat that causes two results
//   holds the queue head until both are out, so a run of such beats fills the queue and
//   then stalls the input.
// Reset (rst, synchronous): phase returns to start, queue empties, no result is valid.
module quoted_key_value_tokenizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  qkvt_pkg::in_beat_t  byte_beat,
  output logic                res_valid,
  input  logic                res_stall,
  output qkvt_pkg::out_beat_t res_beat
);

  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  qkvt_pkg::act_t push_data;
  qkvt_pkg::act_t head;

  assign byte_stall = full;

  // Classify bytes and run the phase machine
  qkvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .full      (full),
    .byte_beat (byte_beat),
    .push      (push),
    .push_data (push_data)
  );

  // Decouple classification from result delivery
  qkvt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Deliver result beats
  qkvt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_beat (res_beat)
  );

endmodule

// ----- rtl/qkvt_check.sv -----
`include "quoted_key_value_tokenizer_core_assert.svh"

module qkvt_check (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input qkvt_pkg::in_beat_t  byte_beat,
  input logic                res_valid,
  input logic                res_stall,
  input qkvt_pkg::out_beat_t res_beat
);

  // Stalled result beat holds
  `QKVT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_beat))

  // Only key and value beats carry a byte
  `QKVT_ASSERT_NOW(a_data_zero, res_valid && (res_beat.kind != qkvt_pkg::KIND_KEY) && (res_beat.kind != qkvt_pkg::KIND_VAL), res_beat.data_byte == 8'd0)

  // An error ends the run and carries a code
  `QKVT_ASSERT_NOW(a_err_code, res_valid && (res_beat.kind == qkvt_pkg::KIND_ERR), res_beat.last_of_run && (res_beat.error_code != qkvt_pkg::ERR_NONE))

  // Non-error beats carry no code
  `QKVT_ASSERT_NOW(a_no_code, res_valid && (res_beat.kind != qkvt_pkg::KIND_ERR), res_beat.error_code == qkvt_pkg::ERR_NONE)

  // Done and pair beats always end their run
  `QKVT_ASSERT_NOW(a_done_last, res_valid && ((res_beat.kind == qkvt_pkg::KIND_DONE) || (res_beat.kind == qkvt_pkg::KIND_PAIR)), res_beat.last_of_run)

endmodule

bind quoted_key_value_tokenizer_core qkvt_check u_check (.*);

// ----- dv/quoted_key_value_tokenizer_core_tb.sv -----
`timescale 1ns / 100ps

module quoted_key_value_tokenizer_core_tb;

  // Phases of the tokenizer as tracked by the testbench
  localparam logic [3:0] P_START      = 4'd0;
  localparam logic [3:0] P_BETWEEN    = 4'd1;
  localparam logic [3:0] P_KEY        = 4'd2;
  localparam logic [3:0] P_AFTER_KEY  = 4'd3;
  localparam logic [3:0] P_BEFORE_VAL = 4'd4;
  localparam logic [3:0] P_VALUE      = 4'd5;
  localparam logic [3:0] P_ESCAPE     = 4'd6;
  localparam logic [3:0] P_AFTER_VAL  = 4'd7;
  localparam logic [3:0] P_HALTED     = 4'd8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  qkvt_pkg::in_beat_t  byte_beat = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  qkvt_pkg::out_beat_t res_beat;

  logic [3:0]          tok_phase = P_START;
  qkvt_pkg::out_beat_t expected_results[$];
  int                  mismatches = 0;
  int                  sent_items = 0;

  // Idling and pressure controls
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Shaping of random content
  int    noise_pct = 0;
  int    cut_left = 0;
  string key_chars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_#";

  quoted_key_value_tokenizer_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic bit blank_char(input logic [7:0] c);
    return c inside {qkvt_pkg::CH_SPACE, qkvt_pkg::CH_TAB, qkvt_pkg::CH_CR,
                     qkvt_pkg::CH_LF};
  endfunction

  function automatic bit key_char_ok(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     qkvt_pkg::CH_UNDER, qkvt_pkg::CH_HASH};
  endfunction

  function automatic qkvt_pkg::out_beat_t mk(input logic [2:0] k, input logic [7:0] d,
                                             input logic [3:0] e);
    return '{kind: k, data_byte: d, error_code: e, last_of_run: 1'b0};
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Advance the tokenizer phase by one beat and queue the results it causes
  function automatic void tokenize_beat(input logic [7:0] c, input logic eop);
    qkvt_pkg::out_beat_t burst[$];
    if (eop) begin
      case (tok_phase)
        P_START:   burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_EMPTY));
        P_BETWEEN: burst.push_back(mk(qkvt_pkg::KIND_DONE, 8'h00, qkvt_pkg::ERR_NONE));
        P_KEY:     burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_QAFTER));
        P_HALTED:  ;
        default:   burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_EOF));
      endcase
      tok_phase = P_START;
    end else begin
      case (tok_phase)
        P_START, P_BETWEEN: begin
          if (c == qkvt_pkg::CH_QUOTE) tok_phase = P_KEY;
          else if (blank_char(c)) tok_phase = P_BETWEEN;
          else begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_QBEFORE));
            tok_phase = P_HALTED;
          end
        end
        P_KEY: begin
          if (c == qkvt_pkg::CH_QUOTE) tok_phase = P_AFTER_KEY;
          else if (key_char_ok(c)) burst.push_back(mk(qkvt_pkg::KIND_KEY, c, qkvt_pkg::ERR_NONE));
          else begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_QAFTER));
            tok_phase = P_HALTED;
          end
        end
        P_AFTER_KEY: begin
          if (c == qkvt_pkg::CH_EQ) tok_phase = P_BEFORE_VAL;
          else if (!blank_char(c)) begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_EQUALS));
            tok_phase = P_HALTED;
          end
        end
        P_BEFORE_VAL: begin
          if (c == qkvt_pkg::CH_QUOTE) tok_phase = P_VALUE;
          else if (!blank_char(c)) begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_STRSTART));
            tok_phase = P_HALTED;
          end
        end
        P_VALUE: begin
          if (c == qkvt_pkg::CH_QUOTE) tok_phase = P_AFTER_VAL;
          else if (c == qkvt_pkg::CH_LF) begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_NEWLINE));
            tok_phase = P_HALTED;
          end else if (c == qkvt_pkg::CH_BSL) tok_phase = P_ESCAPE;
          else burst.push_back(mk(qkvt_pkg::KIND_VAL, c, qkvt_pkg::ERR_NONE));
        end
        P_ESCAPE: begin
          tok_phase = P_VALUE;
          if (c == qkvt_pkg::CH_QUOTE || c == qkvt_pkg::CH_BSL)
            burst.push_back(mk(qkvt_pkg::KIND_VAL, c, qkvt_pkg::ERR_NONE));
          else if (c == qkvt_pkg::CH_N)
            burst.push_back(mk(qkvt_pkg::KIND_VAL, qkvt_pkg::CH_LF, qkvt_pkg::ERR_NONE));
          else begin
            // keep the backslash, then treat the byte as plain value content
            burst.push_back(mk(qkvt_pkg::KIND_VAL, qkvt_pkg::CH_BSL, qkvt_pkg::ERR_NONE));
            if (c == qkvt_pkg::CH_LF) begin
              burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_NEWLINE));
              tok_phase = P_HALTED;
            end else burst.push_back(mk(qkvt_pkg::KIND_VAL, c, qkvt_pkg::ERR_NONE));
          end
        end
        P_AFTER_VAL: begin
          if (c == qkvt_pkg::CH_SEMI) begin
            burst.push_back(mk(qkvt_pkg::KIND_PAIR, 8'h00, qkvt_pkg::ERR_NONE));
            tok_phase = P_BETWEEN;
          end else if (!blank_char(c)) begin
            burst.push_back(mk(qkvt_pkg::KIND_ERR, 8'h00, qkvt_pkg::ERR_SEMI));
            tok_phase = P_HALTED;
          end
        end
        default: tok_phase = P_HALTED;
      endcase
    end
    if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
    foreach (burst[i]) expected_results.push_back(burst[i]);
  endfunction

  // Drive the receiver stall: long hold-offs first, else random idling
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall = 1'b1;
    end else begin
      res_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    qkvt_pkg::out_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: kind %0d data %02h code %0d last %0b",
                             res_beat.kind, res_beat.data_byte, res_beat.error_code,
                             res_beat.last_of_run));
      end else begin
        want = expected_results.pop_front();
        if (res_beat.kind !== want.kind || res_beat.data_byte !== want.data_byte ||
            res_beat.error_code !== want.error_code ||
            res_beat.last_of_run !== want.last_of_run) begin
          flag_error($sformatf({"result mismatch: exp kind %0d data %02h code %0d last %0b,",
                                " got kind %0d data %02h code %0d last %0b"},
                               want.kind, want.data_byte, want.error_code, want.last_of_run,
                               res_beat.kind, res_beat.data_byte, res_beat.error_code,
                               res_beat.last_of_run));
        end
      end
    end
  end

  // Offer one beat from a falling edge and hold it until accepted
  task automatic send_beat(input logic [7:0] c, input logic eop);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid = 1'b0;
      @(negedge clk);
    end
    byte_beat  = '{byte_in: c, end_mark: eop};
    byte_valid = 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent_items++;
    tokenize_beat(c, eop);
    @(negedge clk);
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    byte_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Send a content byte unless the stream is cut short; corrupt it at the noise rate
  task automatic put_byte(input logic [7:0] c);
    if (cut_left == 0) return;
    cut_left--;
    if ($urandom_range(0, 99) < noise_pct) c = 8'($urandom_range(0, 255));
    send_beat(c, 1'b0);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: put_byte(qkvt_pkg::CH_SPACE);
        1: put_byte(qkvt_pkg::CH_TAB);
        2: put_byte(qkvt_pkg::CH_CR);
        default: put_byte(qkvt_pkg::CH_LF);
      endcase
    end
  endtask

  task automatic send_value_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: begin put_byte(qkvt_pkg::CH_BSL); put_byte(qkvt_pkg::CH_QUOTE); end
      1: begin put_byte(qkvt_pkg::CH_BSL); put_byte(qkvt_pkg::CH_BSL); end
      2: begin put_byte(qkvt_pkg::CH_BSL); put_byte(qkvt_pkg::CH_N); end
      3: begin put_byte(qkvt_pkg::CH_BSL); put_byte(8'($urandom_range(0, 255))); end
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == qkvt_pkg::CH_QUOTE || c == qkvt_pkg::CH_BSL) c = 8'h76;
        put_byte(c);
      end
    endcase
  endtask

  // One content stream of well-formed pairs, sometimes corrupted or cut short
  task automatic send_random_content();
    int pairs;
    noise_pct = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    cut_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : 1_000_000;
    pairs     = $urandom_range(0, 4);
    send_blanks();
    repeat (pairs) begin
      put_byte(qkvt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 5)) put_byte(key_chars[$urandom_range(0, key_chars.len() - 1)]);
      put_byte(qkvt_pkg::CH_QUOTE);
      send_blanks();
      put_byte(qkvt_pkg::CH_EQ);
      send_blanks();
      put_byte(qkvt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) send_value_char();
      put_byte(qkvt_pkg::CH_QUOTE);
      send_blanks();
      put_byte(qkvt_pkg::CH_SEMI);
      send_blanks();
    end
    send_end();
  endtask

  task automatic test_empty_content();
    send_end();
  endtask

  task automatic test_blank_content();
    send_beat(qkvt_pkg::CH_CR, 1'b0);
    send_text(" \t");
    send_end();
  endtask

  // Empty key, bad escape before a plain byte and before a newline, then halted
  task automatic test_bad_escapes();
    send_text("\"\"=\"\\x\\\n!");
    send_end();
  endtask

  task automatic test_end_inside_key();
    send_text("\"k");
    send_end();
  endtask

  task automatic test_escape_pair();
    send_text("\"#9\"=\"\\n\\\"\\\\\";");
    send_end();
  endtask

  task automatic test_random_content(input int send_pct, input int recv_pct,
                                     input int beats);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = sent_items + beats;
    while (sent_items < goal) send_random_content();
    wait_drained();
  endtask

  // Hold off the receiver while the sender keeps offering beats
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    hold_go++;
    do send_random_content(); while (hold_go != hold_seen || hold_left > 0);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    test_empty_content();
    test_blank_content();
    test_bad_escapes();
    test_end_inside_key();
    test_escape_pair();
    wait_drained();
    test_random_content(20, 77, 210);
    test_random_content(77, 20, 210);
    test_random_content(0, 0, 220);
    test_backpressure();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
